FILE: design/zsa_pkg.sv
// shared types, constants and codes of the zonal statistics accumulator
package zsa_pkg;

   // store geometry and field widths
   localparam int ZONE_COUNT  = 256;
   localparam int ZONE_BITS   = $clog2(ZONE_COUNT);
   localparam int ZONE_WIDTH  = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int SUM_WIDTH   = 48;
   localparam int STAT_WIDTH  = 48;
   localparam int CNT_WIDTH   = 24;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 88;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 2;

   // mean divider: one quotient bit per cycle
   localparam int DIV_STEPS       = SUM_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS + 1);

   localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      MODE_SUM,
      MODE_MEAN,
      MODE_MIN,
      MODE_MAX
   } mode_type;

   typedef enum logic {
      OP_ACCUM,
      OP_READ
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE,
      CSR_SKIP
   } csr_index_type;

   // one zone record
   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] acc;
      logic [CNT_WIDTH-1:0]        cnt;
      logic                        poison;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;   // capture the accepted item and start the record lookup
      logic commit;      // update or clear the record, capture read results
      logic div_start;   // launch the mean division
      logic rsp_load;    // move the result into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_read;
      logic need_div;
      logic div_done;
      logic rsp_busy;
   } dp_status_type;

endpackage

FILE: design/zsa_divider.sv
// iterative signed-by-unsigned divider for the zone mean, one quotient bit per cycle
module zsa_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [zsa_pkg::SUM_WIDTH-1:0]  dividend,
   input  logic        [zsa_pkg::CNT_WIDTH-1:0]  divisor,
   output logic                                  done,
   output logic signed [zsa_pkg::SUM_WIDTH-1:0]  quotient
);

   logic                                   run_ff;
   logic                                   done_ff;
   logic [zsa_pkg::DIV_COUNT_WIDTH-1:0]    count_ff;
   logic                                   neg_ff;
   logic [zsa_pkg::SUM_WIDTH-1:0]          work_ff;
   logic [zsa_pkg::CNT_WIDTH-1:0]          rem_ff;
   logic [zsa_pkg::CNT_WIDTH-1:0]          div_ff;

   logic [zsa_pkg::SUM_WIDTH-1:0]          abs_in;
   logic [zsa_pkg::CNT_WIDTH:0]            shifted;
   logic [zsa_pkg::CNT_WIDTH:0]            diff;
   logic                                   fits;
   logic [zsa_pkg::CNT_WIDTH-1:0]          rem_in;
   logic [zsa_pkg::SUM_WIDTH-1:0]          mag;

   // magnitude of the most negative sum still fits unsigned
   assign abs_in  = dividend[zsa_pkg::SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;

   // restoring step
   assign shifted = {rem_ff, work_ff[zsa_pkg::SUM_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};
   assign rem_in  = fits ? diff[zsa_pkg::CNT_WIDTH-1:0] : shifted[zsa_pkg::CNT_WIDTH-1:0];

   // truncation toward zero: divide magnitudes, restore sign
   assign mag      = neg_ff ? (~work_ff + 1'b1) : work_ff;
   assign quotient = signed'(mag);
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= zsa_pkg::DIV_COUNT_WIDTH'(zsa_pkg::DIV_STEPS);
         end else if (run_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == zsa_pkg::DIV_COUNT_WIDTH'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[zsa_pkg::SUM_WIDTH-1];
         work_ff <= abs_in;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (run_ff) begin
         work_ff <= {work_ff[zsa_pkg::SUM_WIDTH-2:0], fits};
         rem_ff  <= rem_in;
      end
   end

endmodule

FILE: design/zsa_datapath.sv
// zone record store, update logic, result and configuration registers
module zsa_datapath (
   input  logic                                       clock,
   input  logic                                       reset,
   input  zsa_pkg::ctrl_cmd_type                      cmd,
   output zsa_pkg::dp_status_type                     status,
   input  logic                                       req_operation,
   input  logic        [zsa_pkg::ZONE_WIDTH-1:0]      req_zone,
   input  logic                                       req_zone_missing,
   input  logic signed [zsa_pkg::VALUE_WIDTH-1:0]     req_value,
   input  logic                                       req_value_missing,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic        [zsa_pkg::ZONE_WIDTH-1:0]      rsp_zone_out,
   output logic signed [zsa_pkg::STAT_WIDTH-1:0]      rsp_stat,
   output logic        [zsa_pkg::CNT_WIDTH-1:0]       rsp_sample_count,
   output logic                                       rsp_empty_res,
   output logic                                       rsp_poisoned,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [zsa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [zsa_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   // configuration
   zsa_pkg::mode_type                      mode_ff;
   logic                                   skip_ff;

   // item under work
   zsa_pkg::op_type                        op_ff;
   logic [zsa_pkg::ZONE_WIDTH-1:0]         zone_ff;
   logic                                   zmiss_ff;
   logic signed [zsa_pkg::VALUE_WIDTH-1:0] value_ff;
   logic                                   vmiss_ff;

   // record store, valid bits make unwritten entries read as zero
   zsa_pkg::entry_type                     mem [zsa_pkg::ZONE_COUNT];
   logic [zsa_pkg::ZONE_COUNT-1:0]         valid_ff;
   zsa_pkg::entry_type                     rd_data_ff;
   logic                                   rd_valid_ff;

   // read results waiting for the output register
   logic [zsa_pkg::ZONE_WIDTH-1:0]         res_zone_ff;
   logic signed [zsa_pkg::STAT_WIDTH-1:0]  res_stat_ff;
   logic [zsa_pkg::CNT_WIDTH-1:0]          res_cnt_ff;
   logic                                   res_empty_ff;
   logic                                   res_poison_ff;
   logic                                   res_mean_ff;

   // output register
   logic                                   rsp_valid_ff;
   logic [zsa_pkg::ZONE_WIDTH-1:0]         rsp_zone_ff;
   logic signed [zsa_pkg::STAT_WIDTH-1:0]  rsp_stat_ff;
   logic [zsa_pkg::CNT_WIDTH-1:0]          rsp_cnt_ff;
   logic                                   rsp_empty_ff;
   logic                                   rsp_poison_ff;

   zsa_pkg::entry_type                     cur;
   zsa_pkg::entry_type                     entry_in;
   logic                                   update_en;
   logic signed [zsa_pkg::SUM_WIDTH-1:0]   value_ext;
   logic signed [zsa_pkg::SUM_WIDTH:0]     sum_wide;
   logic signed [zsa_pkg::SUM_WIDTH-1:0]   acc_sat;
   logic                                   empty_in;
   logic                                   need_div;
   logic signed [zsa_pkg::STAT_WIDTH-1:0]  stat_in;
   logic signed [zsa_pkg::SUM_WIDTH-1:0]   quotient;
   logic                                   div_done;

   localparam logic signed [zsa_pkg::SUM_WIDTH-1:0] AccMax = {1'b0, {(zsa_pkg::SUM_WIDTH-1){1'b1}}};
   localparam logic signed [zsa_pkg::SUM_WIDTH-1:0] AccMin = {1'b1, {(zsa_pkg::SUM_WIDTH-1){1'b0}}};

   assign cur       = rd_valid_ff ? rd_data_ff : '0;
   assign value_ext = {{(zsa_pkg::SUM_WIDTH-zsa_pkg::VALUE_WIDTH){value_ff[zsa_pkg::VALUE_WIDTH-1]}},
                       value_ff};
   assign sum_wide  = {cur.acc[zsa_pkg::SUM_WIDTH-1], cur.acc} +
                      {value_ext[zsa_pkg::SUM_WIDTH-1], value_ext};

   // saturate when the two top bits of the grown sum disagree
   always_comb begin
      if (sum_wide[zsa_pkg::SUM_WIDTH] != sum_wide[zsa_pkg::SUM_WIDTH-1]) begin
         acc_sat = sum_wide[zsa_pkg::SUM_WIDTH] ? AccMin : AccMax;
      end else begin
         acc_sat = sum_wide[zsa_pkg::SUM_WIDTH-1:0];
      end
   end

   // accumulate update of the looked-up record
   always_comb begin
      entry_in  = cur;
      update_en = 1'b0;
      if (!zmiss_ff) begin
         if (vmiss_ff) begin
            if (!skip_ff) begin
               entry_in.poison = 1'b1;
               update_en       = 1'b1;
            end
         end else begin
            update_en = 1'b1;
            case (mode_ff) inside
               zsa_pkg::MODE_SUM, zsa_pkg::MODE_MEAN: begin
                  entry_in.acc = acc_sat;
               end
               zsa_pkg::MODE_MIN: begin
                  if (cur.cnt == '0 || value_ext < cur.acc) entry_in.acc = value_ext;
               end
               default: begin
                  if (cur.cnt == '0 || value_ext > cur.acc) entry_in.acc = value_ext;
               end
            endcase
            if (cur.cnt != zsa_pkg::CNT_MAX) entry_in.cnt = cur.cnt + 1'b1;
         end
      end
   end

   // read results
   assign empty_in = (mode_ff != zsa_pkg::MODE_SUM) && (cur.cnt == '0);
   assign need_div = (mode_ff == zsa_pkg::MODE_MEAN) && !empty_in && !cur.poison;
   assign stat_in  = (cur.poison || empty_in) ? '0 : cur.acc;

   zsa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cur.acc),
      .divisor  (cur.cnt),
      .done     (div_done),
      .quotient (quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= zsa_pkg::MODE_SUM;
         skip_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (zsa_pkg::csr_index_type'(csr_index))
            zsa_pkg::CSR_MODE: mode_ff <= zsa_pkg::mode_type'(csr_data);
            zsa_pkg::CSR_SKIP: skip_ff <= csr_data[0];
         endcase
      end
   end

   // item capture and store access
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff       <= zsa_pkg::op_type'(req_operation);
         zone_ff     <= req_zone;
         zmiss_ff    <= req_zone_missing;
         value_ff    <= req_value;
         vmiss_ff    <= req_value_missing;
         rd_data_ff  <= mem[req_zone[zsa_pkg::ZONE_BITS-1:0]];
         rd_valid_ff <= valid_ff[req_zone[zsa_pkg::ZONE_BITS-1:0]];
      end
      if (cmd.commit && op_ff == zsa_pkg::OP_ACCUM && update_en) begin
         mem[zone_ff[zsa_pkg::ZONE_BITS-1:0]] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         if (op_ff == zsa_pkg::OP_READ) begin
            valid_ff[zone_ff[zsa_pkg::ZONE_BITS-1:0]] <= 1'b0;
         end else if (update_en) begin
            valid_ff[zone_ff[zsa_pkg::ZONE_BITS-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && op_ff == zsa_pkg::OP_READ) begin
         res_zone_ff   <= zone_ff;
         res_stat_ff   <= stat_in;
         res_cnt_ff    <= cur.cnt;
         res_empty_ff  <= empty_in;
         res_poison_ff <= cur.poison;
         res_mean_ff   <= need_div;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_zone_ff   <= res_zone_ff;
         rsp_stat_ff   <= res_mean_ff ? quotient : res_stat_ff;
         rsp_cnt_ff    <= res_cnt_ff;
         rsp_empty_ff  <= res_empty_ff;
         rsp_poison_ff <= res_poison_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_zone_out     = rsp_zone_ff;
   assign rsp_stat         = rsp_stat_ff;
   assign rsp_sample_count = rsp_cnt_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_poisoned     = rsp_poison_ff;
   assign csr_ready        = 1'b1;

   assign status.op_read  = (op_ff == zsa_pkg::OP_READ);
   assign status.need_div = need_div;
   assign status.div_done = div_done;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

FILE: design/zsa_ctrl.sv
// controller state machine sequencing lookup, commit, divide and result
module zsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  zsa_pkg::dp_status_type status,
   output zsa_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
            if (!status.op_read) begin
               state_in = ST_IDLE;
            end else if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // an accepted item is committed in the very next cycle
   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not committed next cycle");

   // the divider only finishes while the controller waits for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // division is launched only for read items
   a_div_for_read: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> status.op_read)
      else $error("division launched for an accumulate item");
`endif

endmodule

FILE: design/zonal_statistics_accumulator_core.sv
// accumulate item: accepted while idle, written back in the exec state; one item at a time
// read (sum, min, max): result captured in the exec state, registered in the result state; one at a time
// read (mean): the 48-step divider runs between the exec and result states; one at a time
// a read waits further while the previous result has not been taken
// reset (synchronous, active high) clears the per-zone valid bits at once, so every record
// reads as zero right away; no clearing pass; mode and skip_missing reset to zero
module zonal_statistics_accumulator_core (
   input  logic                                       clock,
   input  logic                                       reset,
   // item input
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // zone[7:0], zone_missing[8], value[40:9], value_missing[41], zero pad[47:42]
   input  logic [zsa_pkg::REQ_DATA_WIDTH-1:0]         req_tdata,
   // operation[0]
   input  logic                                       req_tuser,
   // result output
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // zone_out[7:0], stat[55:8], sample_count[79:56], empty_res[80], poisoned[81], pad[87:82]
   output logic [zsa_pkg::RSP_DATA_WIDTH-1:0]         rsp_tdata,
   // configuration writes
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [zsa_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [zsa_pkg::CSR_DATA_WIDTH-1:0]         csr_data
);

   localparam int RspUsed = zsa_pkg::ZONE_WIDTH + zsa_pkg::STAT_WIDTH + zsa_pkg::CNT_WIDTH + 2;

   zsa_pkg::ctrl_cmd_type                  cmd;
   zsa_pkg::dp_status_type                 status;

   // unpacked request fields
   logic [zsa_pkg::ZONE_WIDTH-1:0]         req_zone;
   logic                                   req_zone_missing;
   logic signed [zsa_pkg::VALUE_WIDTH-1:0] req_value;
   logic                                   req_value_missing;

   // result fields before packing
   logic                                   rsp_valid;
   logic [zsa_pkg::ZONE_WIDTH-1:0]         rsp_zone_out;
   logic signed [zsa_pkg::STAT_WIDTH-1:0]  rsp_stat;
   logic [zsa_pkg::CNT_WIDTH-1:0]          rsp_sample_count;
   logic                                   rsp_empty_res;
   logic                                   rsp_poisoned;

   assign req_zone          = req_tdata[7:0];
   assign req_zone_missing  = req_tdata[8];
   assign req_value         = signed'(req_tdata[40:9]);
   assign req_value_missing = req_tdata[41];

   // sequencer: one item in flight, lookup then commit, optional divide, result hand-off
   zsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // record store, arithmetic, divider and output register
   zsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_tuser),
      .req_zone          (req_zone),
      .req_zone_missing  (req_zone_missing),
      .req_value         (req_value),
      .req_value_missing (req_value_missing),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_tready),
      .rsp_zone_out      (rsp_zone_out),
      .rsp_stat          (rsp_stat),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_empty_res     (rsp_empty_res),
      .rsp_poisoned      (rsp_poisoned),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   assign rsp_tvalid = rsp_valid;

   // pack result fields, lowest field first, zero pad to whole bytes
   assign rsp_tdata = {{(zsa_pkg::RSP_DATA_WIDTH-RspUsed){1'b0}},
                       rsp_poisoned,
                       rsp_empty_res,
                       rsp_sample_count,
                       rsp_stat,
                       rsp_zone_out};

endmodule

FILE: tb/sv/zonal_statistics_accumulator_core_test.sv
// self-checking testbench of the zonal statistics accumulator core
module zonal_statistics_accumulator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // run limits
   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned SETTLE_CYCLES = 8;      // lets the last accumulate write-back finish
   localparam int unsigned END_CYCLES    = 60;     // longer than a mean read
   localparam int unsigned HOLD_CYCLES   = 300;    // receiver hold-off stretch
   localparam int unsigned BURST_ITEMS   = 8;      // large pixels of one sign, back to back
   localparam int unsigned PHASE_ITEMS   = 175;

   localparam longint SUM_HI = (longint'(1) <<< (zsa_pkg::SUM_WIDTH - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   // one pixel or read item as the sender offers it
   typedef struct {
      zsa_pkg::op_type                          op;
      logic [zsa_pkg::ZONE_WIDTH-1:0]           zone;
      logic                                     zone_missing;
      logic signed [zsa_pkg::VALUE_WIDTH-1:0]   value;
      logic                                     value_missing;
      bit                                       no_gap;    // offer without a random gap
   } pixel_item_type;

   // one zone report as the block should return it
   typedef struct {
      logic [zsa_pkg::ZONE_WIDTH-1:0]           zone;
      logic signed [zsa_pkg::STAT_WIDTH-1:0]    stat;
      logic [zsa_pkg::CNT_WIDTH-1:0]            count;
      logic                                     empty;
      logic                                     poisoned;
   } zone_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // zone[7:0], zone_missing[8], value[40:9], value_missing[41], zero pad[47:42]
   logic [zsa_pkg::REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   // operation[0]
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // zone_out[7:0], stat[55:8], sample_count[79:56], empty_res[80], poisoned[81], pad[87:82]
   logic [zsa_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [zsa_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [zsa_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   zonal_statistics_accumulator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted zone records and register settings
   logic signed [zsa_pkg::SUM_WIDTH-1:0] zone_total   [zsa_pkg::ZONE_COUNT];
   logic [zsa_pkg::CNT_WIDTH-1:0]        zone_samples [zsa_pkg::ZONE_COUNT];
   logic                                 zone_tainted [zsa_pkg::ZONE_COUNT];
   zsa_pkg::mode_type                    mode_setting = zsa_pkg::MODE_SUM;
   logic                                 skip_setting = 1'b0;

   zone_report_type expected_reports [$];
   pixel_item_type  feed_queue [$];
   pixel_item_type  offered;
   bit              offered_taken = 1'b0;
   int unsigned     items_outstanding = 0;
   int unsigned     req_idle_pct = 35;
   int unsigned     rsp_idle_pct = 35;
   int unsigned     hold_asked = 0;
   int unsigned     hold_granted = 0;
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   logic [zsa_pkg::ZONE_WIDTH-1:0] hot_zones [8];

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   // apply one accepted item to the predicted records; a read queues its report
   function automatic void predict_zone_item(input pixel_item_type it);
      zone_report_type rpt;
      longint          running;
      if (it.op == zsa_pkg::OP_ACCUM) begin
         // pixels with a no-data zone never touch a record
         if (it.zone_missing)
            return;
         // a no-data value poisons the zone unless skipping, count and sum stay put
         if (it.value_missing) begin
            if (!skip_setting)
               zone_tainted[it.zone] = 1'b1;
            return;
         end
         if (mode_setting == zsa_pkg::MODE_SUM || mode_setting == zsa_pkg::MODE_MEAN) begin
            // running sum clamps at the signed accumulator limits
            running = longint'(zone_total[it.zone]) + longint'(it.value);
            if (running > SUM_HI)
               running = SUM_HI;
            else if (running < SUM_LO)
               running = SUM_LO;
            zone_total[it.zone] = running[zsa_pkg::SUM_WIDTH-1:0];
         end else if (zone_samples[it.zone] == 0) begin
            // first value of a min or max record is loaded as is
            zone_total[it.zone] = it.value;
         end else if (mode_setting == zsa_pkg::MODE_MIN) begin
            if (it.value < zone_total[it.zone])
               zone_total[it.zone] = it.value;
         end else begin
            if (it.value > zone_total[it.zone])
               zone_total[it.zone] = it.value;
         end
         if (zone_samples[it.zone] != zsa_pkg::CNT_MAX)
            zone_samples[it.zone] = zone_samples[it.zone] + 1'b1;
      end else begin
         rpt.zone     = it.zone;
         rpt.count    = zone_samples[it.zone];
         rpt.poisoned = zone_tainted[it.zone];
         rpt.empty    = (mode_setting != zsa_pkg::MODE_SUM) && (zone_samples[it.zone] == 0);
         if (rpt.poisoned || rpt.empty) begin
            rpt.stat = '0;
         end else if (mode_setting == zsa_pkg::MODE_MEAN) begin
            // integer division truncates toward zero
            running  = longint'(zone_total[it.zone]) / longint'(zone_samples[it.zone]);
            rpt.stat = running[zsa_pkg::STAT_WIDTH-1:0];
         end else begin
            rpt.stat = zone_total[it.zone];
         end
         // a read clears the record
         zone_total[it.zone]   = '0;
         zone_samples[it.zone] = '0;
         zone_tainted[it.zone] = 1'b0;
         expected_reports.insert(expected_reports.size(), rpt);
      end
   endfunction

   // sender: offers the next pending item at the falling edge, gaps at random unless no_gap is set
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || offered_taken) begin
         if (feed_queue.size() != 0 &&
             (feed_queue[0].no_gap || $urandom_range(99) >= req_idle_pct)) begin
            offered = feed_queue.pop_front();
            req_tuser  <= offered.op;
            req_tdata  <= {6'b0, offered.value_missing, offered.value,
                           offered.zone_missing, offered.zone};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // acceptance of an item updates the prediction
   always @(posedge clock) begin
      offered_taken = !reset && req_tvalid && req_tready;
      if (offered_taken) begin
         predict_zone_item(offered);
         items_outstanding--;
      end
   end

   // receiver ready: random stalls, plus a long hold-off on request
   always @(negedge clock) begin : rsp_ready_drive
      int unsigned hold_left;
      if (reset) begin
         hold_left = 0;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_granted) begin
         hold_granted++;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // result checker: each taken result against the oldest prediction
   always @(posedge clock) begin : report_check
      zone_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result with no read pending, zone", rsp_tdata[7:0], -1);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tdata[7:0] !== want.zone)
               report_mismatch("zone_out", rsp_tdata[7:0], want.zone);
            if (rsp_tdata[55:8] !== want.stat)
               report_mismatch("stat", $signed(rsp_tdata[55:8]), want.stat);
            if (rsp_tdata[79:56] !== want.count)
               report_mismatch("sample_count", rsp_tdata[79:56], want.count);
            if (rsp_tdata[80] !== want.empty)
               report_mismatch("empty_res", rsp_tdata[80], want.empty);
            if (rsp_tdata[81] !== want.poisoned)
               report_mismatch("poisoned", rsp_tdata[81], want.poisoned);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_item(zsa_pkg::op_type op, int zone, bit zmiss, logic [31:0] value,
                             bit vmiss, bit steady = 1'b0);
      pixel_item_type it;
      it.op            = op;
      it.zone          = zone[zsa_pkg::ZONE_WIDTH-1:0];
      it.zone_missing  = zmiss;
      it.value         = value;
      it.value_missing = vmiss;
      it.no_gap        = steady;
      feed_queue.insert(feed_queue.size(), it);
      items_outstanding++;
   endtask

   // mostly a handful of hot zones so reads find filled records
   function automatic pixel_item_type random_pixel();
      pixel_item_type it;
      it.op            = ($urandom_range(99) < 15) ? zsa_pkg::OP_READ : zsa_pkg::OP_ACCUM;
      it.zone          = ($urandom_range(99) < 80) ? hot_zones[$urandom_range(7)]
                                                   : zsa_pkg::ZONE_WIDTH'($urandom);
      it.zone_missing  = ($urandom_range(99) < 5);
      it.value_missing = ($urandom_range(99) < 8);
      it.no_gap        = 1'b0;
      case ($urandom_range(3))
         0: it.value = $urandom;
         1: it.value = (int'($urandom_range(2000)) - 1000) <<< 16;
         2: it.value = int'($urandom_range(200)) - 100;
         default: begin
            case ($urandom_range(3))
               0: it.value = 32'h7FFF_FFFF;
               1: it.value = 32'h8000_0000;
               2: it.value = '0;
               default: it.value = '1;
            endcase
         end
      endcase
      return it;
   endfunction

   // wait until every item is in and every read answered, then let write-back finish
   task automatic drain_zone_traffic();
      while (items_outstanding != 0 || expected_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(zsa_pkg::csr_index_type idx,
                                 logic [zsa_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == zsa_pkg::CSR_MODE)
         mode_setting = zsa_pkg::mode_type'(data);
      else
         skip_setting = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // only the low bit of the skip register counts, the upper data bit is random
   task automatic configure(zsa_pkg::mode_type m, bit skip);
      write_register(zsa_pkg::CSR_MODE, m);
      write_register(zsa_pkg::CSR_SKIP, {1'($urandom), skip});
   endtask

   initial begin : stimulus
      zsa_pkg::mode_type phase_mode [8];
      bit                phase_skip [8];
      pixel_item_type    it;

      phase_mode = '{zsa_pkg::MODE_SUM, zsa_pkg::MODE_MEAN, zsa_pkg::MODE_MIN,
                     zsa_pkg::MODE_MAX, zsa_pkg::MODE_MEAN, zsa_pkg::MODE_SUM,
                     zsa_pkg::MODE_MIN, zsa_pkg::MODE_MAX};
      phase_skip = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      for (int z = 0; z < zsa_pkg::ZONE_COUNT; z++) begin
         zone_total[z]   = '0;
         zone_samples[z] = '0;
         zone_tainted[z] = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sum mode after reset: extremes cancel out on zone 0
      queue_item(zsa_pkg::OP_ACCUM, 0, 0, 32'h7FFF_FFFF, 0);
      queue_item(zsa_pkg::OP_ACCUM, 0, 0, 32'h8000_0000, 0);
      queue_item(zsa_pkg::OP_ACCUM, 0, 0, 32'h0000_0001, 0);
      queue_item(zsa_pkg::OP_READ,  0, 0, '0, 0);
      // no-data value poisons the top zone
      queue_item(zsa_pkg::OP_ACCUM, 255, 0, -32'sd5, 0);
      queue_item(zsa_pkg::OP_ACCUM, 255, 0, 32'h1234_5678, 1);
      queue_item(zsa_pkg::OP_READ,  255, 0, '0, 0);
      // no-data zone pixels are dropped, empty sum record is not flagged empty
      queue_item(zsa_pkg::OP_ACCUM, 3, 1, 32'h0064_0000, 0);
      queue_item(zsa_pkg::OP_ACCUM, 3, 1, 32'hFFFF_FFFF, 1);
      queue_item(zsa_pkg::OP_READ,  3, 0, '0, 0);
      queue_item(zsa_pkg::OP_READ,  200, 1, 32'hFFFF_FFFF, 1);
      drain_zone_traffic();

      // mean with skipping, negative mean truncates toward zero
      configure(zsa_pkg::MODE_MEAN, 1'b1);
      queue_item(zsa_pkg::OP_ACCUM, 5, 0, -32'sd7, 0);
      queue_item(zsa_pkg::OP_ACCUM, 5, 0, 32'h7FFF_0000, 1);
      queue_item(zsa_pkg::OP_ACCUM, 5, 0, 32'sd2, 0);
      queue_item(zsa_pkg::OP_READ,  5, 0, '0, 0);
      queue_item(zsa_pkg::OP_READ,  6, 0, '0, 0);
      drain_zone_traffic();

      // min, first value loads the record, re-read is empty
      configure(zsa_pkg::MODE_MIN, 1'b0);
      queue_item(zsa_pkg::OP_ACCUM, 9, 0, 32'sd10, 0);
      queue_item(zsa_pkg::OP_ACCUM, 9, 0, -32'sd3, 0);
      queue_item(zsa_pkg::OP_ACCUM, 9, 0, 32'sd20, 0);
      queue_item(zsa_pkg::OP_READ,  9, 0, '0, 0);
      queue_item(zsa_pkg::OP_READ,  9, 0, '0, 0);
      drain_zone_traffic();

      // max with negative values, then a mode change on a live record
      configure(zsa_pkg::MODE_MAX, 1'b0);
      queue_item(zsa_pkg::OP_ACCUM, 9, 0, -32'sd100, 0);
      queue_item(zsa_pkg::OP_ACCUM, 9, 0, -32'sd200, 0);
      queue_item(zsa_pkg::OP_READ,  9, 0, '0, 0);
      queue_item(zsa_pkg::OP_ACCUM, 11, 0, 32'sd50, 0);
      drain_zone_traffic();
      configure(zsa_pkg::MODE_MIN, 1'b0);
      queue_item(zsa_pkg::OP_ACCUM, 11, 0, 32'sd80, 0);
      queue_item(zsa_pkg::OP_READ,  11, 0, '0, 0);
      drain_zone_traffic();

      // large positive sum, back to back with no sender gaps
      configure(zsa_pkg::MODE_SUM, 1'b0);
      for (int n = 0; n < BURST_ITEMS; n++)
         queue_item(zsa_pkg::OP_ACCUM, 1, 0, 32'h7FFF_FFFF, 0, 1'b1);
      queue_item(zsa_pkg::OP_READ, 1, 0, '0, 0);
      drain_zone_traffic();

      // mean of a large negative sum
      configure(zsa_pkg::MODE_MEAN, 1'b0);
      for (int n = 0; n < BURST_ITEMS; n++)
         queue_item(zsa_pkg::OP_ACCUM, 2, 0, 32'h8000_0000, 0, 1'b1);
      queue_item(zsa_pkg::OP_READ, 2, 0, '0, 0);
      drain_zone_traffic();

      // random phases over all settings
      for (int p = 0; p < 8; p++) begin
         configure(phase_mode[p], phase_skip[p]);
         foreach (hot_zones[k])
            hot_zones[k] = zsa_pkg::ZONE_WIDTH'($urandom);
         hot_zones[0] = (p % 2 == 0) ? 8'd0 : 8'd255;
         // one phase runs without any idling on either side
         req_idle_pct = (p == 4) ? 0 : 35;
         rsp_idle_pct = (p == 4) ? 0 : 35;
         // receiver holds off while reads keep coming so the input backs up
         if (p == 2)
            hold_asked++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = random_pixel();
            if (p == 2 && n < 20)
               it.op = zsa_pkg::OP_READ;
            feed_queue.insert(feed_queue.size(), it);
            items_outstanding++;
         end
         drain_zone_traffic();
      end

      repeat (END_CYCLES) @(negedge clock);
      if (expected_reports.size() != 0)
         report_mismatch("reads left unanswered", expected_reports.size(), 0);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
